// ----- rtl/core/kct_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kct_pkg
// Shared types, command codes, key codes and the segment decoder of the
// keypad countdown timer.
// ----------------------------------------------------------------------------
package kct_pkg;

   localparam int NUM_DIGITS_DEF  = 4;
   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int DIGIT_W         = 4;
   localparam int SEG_W           = 7;
   localparam int SEC_W           = 14;
   localparam int TPS_W           = 8;
   localparam int PADDR_W         = 3;
   localparam int PDATA_W         = 32;
   localparam int SEC_MAX_INT     = 16383;

   localparam logic [SEC_W-1:0] SEC_MAX   = SEC_W'(SEC_MAX_INT);
   localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(40);

   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [DIGIT_W-1:0] KEY_ZERO = 4'd10;
   localparam logic [DIGIT_W-1:0] KEY_STAR = 4'd11;
   localparam logic [DIGIT_W-1:0] KEY_HASH = 4'd12;

   localparam int CMD_W = 3;
   localparam logic [CMD_W-1:0] CMD_NOP   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DIGIT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TICK  = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]   kind;
      logic [DIGIT_W-1:0] digit;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] s;
      case (d)
         4'd0:    s = 7'h3F;
         4'd1:    s = 7'h06;
         4'd2:    s = 7'h5B;
         4'd3:    s = 7'h4F;
         4'd4:    s = 7'h66;
         4'd5:    s = 7'h6D;
         4'd6:    s = 7'h7D;
         4'd7:    s = 7'h07;
         4'd8:    s = 7'h7F;
         4'd9:    s = 7'h6F;
         4'd10:   s = 7'h3F;
         default: s = 7'h00;
      endcase
      return s;
   endfunction

   function automatic int pow10(input int n);
      int r;
      r = 1;
      for (int i = 0; i < n; i++) begin
         r = r * 10;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/kct_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kct_front
// Request front end: takes key and tick beats and turns them into commands.
// ----------------------------------------------------------------------------
module kct_front (
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_opcode,
   input  wire logic [kct_pkg::DIGIT_W-1:0]   req_key_code,
   input  wire kct_pkg::q_status_type         q_status,
   output logic                               push,
   output kct_pkg::cmd_type                   push_cmd
);

   assign req_ready = !q_status.full;
   assign push      = req_valid && req_ready;

   always_comb begin
      push_cmd.digit = req_key_code;
      if (req_opcode == kct_pkg::OP_TICK) begin
         push_cmd.kind = kct_pkg::CMD_TICK;
      end else if (req_key_code <= kct_pkg::KEY_ZERO) begin
         push_cmd.kind = kct_pkg::CMD_DIGIT;
      end else if (req_key_code == kct_pkg::KEY_STAR) begin
         push_cmd.kind = kct_pkg::CMD_CLEAR;
      end else if (req_key_code == kct_pkg::KEY_HASH) begin
         push_cmd.kind = kct_pkg::CMD_LOAD;
      end else begin
         push_cmd.kind = kct_pkg::CMD_NOP;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/kct_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kct_queue
// Short command queue between the front end and the execution back end.
// ----------------------------------------------------------------------------
module kct_queue #(
   parameter int QUEUE_DEPTH = kct_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire kct_pkg::cmd_type      push_cmd,
   input  wire logic                  pop,
   output kct_pkg::cmd_type           pop_cmd,
   output kct_pkg::q_status_type      q_status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   kct_pkg::cmd_type  entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff,  count_in;

   assign q_status.full  = (count_ff == CNT_FULL);
   assign q_status.empty = (count_ff == '0);
   assign pop_cmd        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/kct_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kct_back
// Execution back end: digit store, seconds counter with decimal shadow,
// tick prescaler and the registered result beat.
// ----------------------------------------------------------------------------
module kct_back #(
   parameter int NUM_DIGITS = kct_pkg::NUM_DIGITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [kct_pkg::TPS_W-1:0]     ticks_per_second,
   input  wire kct_pkg::cmd_type              cmd,
   input  wire kct_pkg::q_status_type         q_status,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [kct_pkg::DIGIT_W-1:0]        rsp_digit_thousands,
   output logic [kct_pkg::DIGIT_W-1:0]        rsp_digit_hundreds,
   output logic [kct_pkg::DIGIT_W-1:0]        rsp_digit_tens,
   output logic [kct_pkg::DIGIT_W-1:0]        rsp_digit_ones,
   output logic [kct_pkg::SEG_W-1:0]          rsp_seg_thousands,
   output logic [kct_pkg::SEG_W-1:0]          rsp_seg_hundreds,
   output logic [kct_pkg::SEG_W-1:0]          rsp_seg_tens,
   output logic [kct_pkg::SEG_W-1:0]          rsp_seg_ones,
   output logic [kct_pkg::SEC_W-1:0]          rsp_seconds_remaining,
   output logic                               rsp_running,
   output logic                               rsp_finished
);

   localparam int DW     = kct_pkg::DIGIT_W;
   localparam int SW     = kct_pkg::SEC_W;
   localparam int RAW_W  = $clog2(10 ** NUM_DIGITS);
   localparam int SUM_W  = (RAW_W > SW) ? RAW_W : SW;
   localparam int SHOWN  = 4;

   logic [DW-1:0] digit_ff [NUM_DIGITS];
   logic [DW-1:0] digit_in [NUM_DIGITS];
   logic [DW-1:0] bcd_ff   [NUM_DIGITS];
   logic [DW-1:0] bcd_in   [NUM_DIGITS];
   logic [DW-1:0] mapped   [NUM_DIGITS];
   logic [DW-1:0] sat_bcd  [NUM_DIGITS];
   logic [DW-1:0] bcd_dec  [NUM_DIGITS];
   logic [SUM_W-1:0] term  [NUM_DIGITS];
   logic [SUM_W-1:0] sum;
   logic             sat;

   logic [SW-1:0]                  sec_ff, sec_in, sec_dec;
   logic [kct_pkg::TPS_W-1:0]      presc_ff, presc_in, presc_inc;
   logic                           lock_ff, lock_in;
   logic                           run_ff, run_in;
   logic                           done;
   logic                           borrow;

   logic [DW-1:0]                  disp     [SHOWN];
   logic [kct_pkg::SEG_W-1:0]      disp_seg [SHOWN];

   logic                           rsp_valid_ff;
   logic [DW-1:0]                  rsp_digit_ff [SHOWN];
   logic [kct_pkg::SEG_W-1:0]      rsp_seg_ff   [SHOWN];
   logic [SW-1:0]                  rsp_sec_ff;
   logic                           rsp_run_ff;
   logic                           rsp_done_ff;

   assign pop = !q_status.empty && (!rsp_valid_ff || rsp_ready);

   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_digit
      localparam int SAT_DIGIT =
         (kct_pkg::SEC_MAX_INT / kct_pkg::pow10(NUM_DIGITS - 1 - i)) % 10;
      assign mapped[i]  = (digit_ff[i] == kct_pkg::KEY_ZERO) ? '0 : digit_ff[i];
      assign sat_bcd[i] = DW'(SAT_DIGIT);
      assign term[i]    = SUM_W'(mapped[i]) *
                          SUM_W'(kct_pkg::pow10(NUM_DIGITS - 1 - i));
   end

   always_comb begin
      sum = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         sum = sum + term[i];
      end
   end

   assign sat = (sum > SUM_W'(kct_pkg::SEC_MAX));

   always_comb begin
      borrow = 1'b1;
      for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
         bcd_dec[i] = bcd_ff[i];
         if (borrow) begin
            if (bcd_ff[i] == '0) begin
               bcd_dec[i] = DW'(9);
            end else begin
               bcd_dec[i] = bcd_ff[i] - DW'(1);
               borrow     = 1'b0;
            end
         end
      end
   end

   assign sec_dec   = (sec_ff != '0) ? sec_ff - SW'(1) : sec_ff;
   assign presc_inc = presc_ff + kct_pkg::TPS_W'(1);

   always_comb begin
      digit_in = digit_ff;
      bcd_in   = bcd_ff;
      sec_in   = sec_ff;
      presc_in = presc_ff;
      lock_in  = lock_ff;
      run_in   = run_ff;
      done     = 1'b0;
      case (cmd.kind)
         kct_pkg::CMD_DIGIT: begin
            if (!lock_ff) begin
               for (int i = 0; i < NUM_DIGITS - 1; i++) begin
                  digit_in[i] = digit_ff[i + 1];
               end
               digit_in[NUM_DIGITS - 1] = cmd.digit;
            end
         end
         kct_pkg::CMD_CLEAR: begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
               digit_in[i] = '0;
            end
            run_in  = 1'b0;
            lock_in = 1'b0;
         end
         kct_pkg::CMD_LOAD: begin
            digit_in = mapped;
            lock_in  = 1'b1;
            if (sat) begin
               sec_in = kct_pkg::SEC_MAX;
               bcd_in = sat_bcd;
            end else begin
               sec_in = sum[SW-1:0];
               bcd_in = mapped;
            end
            if (sum != '0) begin
               run_in = 1'b1;
            end else begin
               lock_in = 1'b0;
            end
         end
         kct_pkg::CMD_TICK: begin
            if (run_ff) begin
               if (presc_inc == ticks_per_second) begin
                  sec_in   = sec_dec;
                  bcd_in   = bcd_dec;
                  digit_in = bcd_dec;
                  presc_in = '0;
                  if (sec_dec == '0) begin
                     run_in  = 1'b0;
                     lock_in = 1'b0;
                     done    = 1'b1;
                  end
               end else begin
                  presc_in = presc_inc;
               end
            end
         end
         default: begin
         end
      endcase
   end

   for (genvar k = 0; k < SHOWN; k++) begin : g_disp
      if (k >= SHOWN - NUM_DIGITS) begin : g_on
         assign disp[k]     = digit_in[NUM_DIGITS - SHOWN + k];
         assign disp_seg[k] = kct_pkg::seg_of(disp[k]);
      end else begin : g_off
         assign disp[k]     = '0;
         assign disp_seg[k] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DIGITS; i++) begin
            digit_ff[i] <= '0;
            bcd_ff[i]   <= '0;
         end
         sec_ff       <= '0;
         presc_ff     <= '0;
         lock_ff      <= 1'b0;
         run_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            digit_ff <= digit_in;
            bcd_ff   <= bcd_in;
            sec_ff   <= sec_in;
            presc_ff <= presc_in;
            lock_ff  <= lock_in;
            run_ff   <= run_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         for (int k = 0; k < SHOWN; k++) begin
            rsp_digit_ff[k] <= disp[k];
            rsp_seg_ff[k]   <= disp_seg[k];
         end
         rsp_sec_ff  <= sec_in;
         rsp_run_ff  <= run_in;
         rsp_done_ff <= done;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_digit_thousands   = rsp_digit_ff[0];
   assign rsp_digit_hundreds    = rsp_digit_ff[1];
   assign rsp_digit_tens        = rsp_digit_ff[2];
   assign rsp_digit_ones        = rsp_digit_ff[3];
   assign rsp_seg_thousands     = rsp_seg_ff[0];
   assign rsp_seg_hundreds      = rsp_seg_ff[1];
   assign rsp_seg_tens          = rsp_seg_ff[2];
   assign rsp_seg_ones          = rsp_seg_ff[3];
   assign rsp_seconds_remaining = rsp_sec_ff;
   assign rsp_running           = rsp_run_ff;
   assign rsp_finished          = rsp_done_ff;

endmodule
`default_nettype wire

// ----- rtl/core/keypad_countdown_timer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_countdown_timer
// Keypad entered countdown timer with seven-segment digit patterns. Each
// request beat is either a key event or a tick and yields exactly one
// response beat carrying the shown digits, their patterns, the seconds left
// and the running and finished flags. The block takes one request beat per
// cycle while the command queue is not full; a response passes through the
// command queue and then the response register, and the queue and the
// response register let either side stall alone. ticks_per_second sits at
// addresses 0 to 3 of the register port (paddr[2] low) and reads back there.
// ----------------------------------------------------------------------------
module keypad_countdown_timer #(
   parameter int NUM_DIGITS  = kct_pkg::NUM_DIGITS_DEF,
   parameter int QUEUE_DEPTH = kct_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_opcode,
   input  wire logic [kct_pkg::DIGIT_W-1:0]   req_key_code,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [kct_pkg::DIGIT_W-1:0]        rsp_digit_thousands,
   output logic [kct_pkg::DIGIT_W-1:0]        rsp_digit_hundreds,
   output logic [kct_pkg::DIGIT_W-1:0]        rsp_digit_tens,
   output logic [kct_pkg::DIGIT_W-1:0]        rsp_digit_ones,
   output logic [kct_pkg::SEG_W-1:0]          rsp_seg_thousands,
   output logic [kct_pkg::SEG_W-1:0]          rsp_seg_hundreds,
   output logic [kct_pkg::SEG_W-1:0]          rsp_seg_tens,
   output logic [kct_pkg::SEG_W-1:0]          rsp_seg_ones,
   output logic [kct_pkg::SEC_W-1:0]          rsp_seconds_remaining,
   output logic                               rsp_running,
   output logic                               rsp_finished,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [kct_pkg::PADDR_W-1:0]   paddr,
   input  wire logic [kct_pkg::PDATA_W-1:0]   pwdata,
   output logic [kct_pkg::PDATA_W-1:0]        prdata,
   output logic                               pready
);

   localparam int TW = kct_pkg::TPS_W;

   logic [TW-1:0]          tps_ff, tps_in;
   logic                   reg_sel;
   logic                   push;
   logic                   pop;
   kct_pkg::cmd_type       push_cmd;
   kct_pkg::cmd_type       pop_cmd;
   kct_pkg::q_status_type  q_status;

   assign pready  = 1'b1;
   assign reg_sel = (paddr[kct_pkg::PADDR_W-1] == 1'b0);
   assign prdata  = reg_sel ? kct_pkg::PDATA_W'(tps_ff) : '0;

   always_comb begin
      tps_in = tps_ff;
      if (psel && penable && pwrite && pready && reg_sel) begin
         tps_in = pwdata[TW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= kct_pkg::TPS_RESET;
      end else begin
         tps_ff <= tps_in;
      end
   end

   kct_front u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_key_code (req_key_code),
      .q_status     (q_status),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   kct_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_status (q_status)
   );

   kct_back #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .ticks_per_second      (tps_ff),
      .cmd                   (pop_cmd),
      .q_status              (q_status),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_digit_thousands   (rsp_digit_thousands),
      .rsp_digit_hundreds    (rsp_digit_hundreds),
      .rsp_digit_tens        (rsp_digit_tens),
      .rsp_digit_ones        (rsp_digit_ones),
      .rsp_seg_thousands     (rsp_seg_thousands),
      .rsp_seg_hundreds      (rsp_seg_hundreds),
      .rsp_seg_tens          (rsp_seg_tens),
      .rsp_seg_ones          (rsp_seg_ones),
      .rsp_seconds_remaining (rsp_seconds_remaining),
      .rsp_running           (rsp_running),
      .rsp_finished          (rsp_finished)
   );

   a_finish_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_finished) |-> (!rsp_running && rsp_seconds_remaining == '0))
      else $error("finished beat with count still active");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty");

   a_pop_to_rsp: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("dequeued command produced no response beat");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !q_status.empty)
      else $error("accepted request beat missing from queue");

endmodule
`default_nettype wire
